// ----- src/c3f_pkg.sv -----
// ----------------------------------------------------------------------------
// c3f_pkg: shared types and constants of the 3x3 image filter
// Holds the configuration struct, the window word that the front passes to
// the back, register indexes, reset values and the coefficient picker.
// ----------------------------------------------------------------------------
package c3f_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int PIX_W      = 8;
	localparam int KROW_W     = 24;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int FILT_W     = 20;
	localparam int PROD_W     = 17;
	localparam int OUT_DATA_W = 24;

	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;

	localparam logic [2:0] REG_KTOP    = 3'd0;
	localparam logic [2:0] REG_KMID    = 3'd1;
	localparam logic [2:0] REG_KBOT    = 3'd2;
	localparam logic [2:0] REG_FWIDTH  = 3'd3;
	localparam logic [2:0] REG_FHEIGHT = 3'd4;

	localparam logic [KROW_W-1:0] KTOP_RST    = 24'hFFFFFF;
	localparam logic [KROW_W-1:0] KMID_RST    = 24'hFF08FF;
	localparam logic [KROW_W-1:0] KBOT_RST    = 24'hFFFFFF;
	localparam logic [FW_W-1:0]   FWIDTH_RST  = 11'd5;
	localparam logic [FH_W-1:0]   FHEIGHT_RST = 13'd6;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic [KROW_W-1:0] k_top;
		logic [KROW_W-1:0] k_mid;
		logic [KROW_W-1:0] k_bot;
		logic [FW_W-1:0]   fwidth;
		logic [FH_W-1:0]   fheight;
	} cfg_t;

	// Window pixel (r, c) sits at index 3*r + c; row 0 is the oldest row.
	typedef struct packed {
		logic           last;
		logic [8:0][PIX_W-1:0] pix;
	} win_item_t;

	function automatic logic signed [PIX_W-1:0] kcoef(input logic [KROW_W-1:0] row,
		input logic [1:0] pos);
		return row[PIX_W*pos +: PIX_W];
	endfunction

endpackage

// ----- src/c3f_regs.sv -----
// ----------------------------------------------------------------------------
// c3f_regs: configuration register file
// APB-style slave holding the three kernel rows and the frame size.
// ----------------------------------------------------------------------------
module c3f_regs import c3f_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_AW-1:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.k_top   <= KTOP_RST;
			cfg.k_mid   <= KMID_RST;
			cfg.k_bot   <= KBOT_RST;
			cfg.fwidth  <= FWIDTH_RST;
			cfg.fheight <= FHEIGHT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_KTOP:    cfg.k_top   <= pwdata[KROW_W-1:0];
				REG_KMID:    cfg.k_mid   <= pwdata[KROW_W-1:0];
				REG_KBOT:    cfg.k_bot   <= pwdata[KROW_W-1:0];
				REG_FWIDTH:  cfg.fwidth  <= pwdata[FW_W-1:0];
				REG_FHEIGHT: cfg.fheight <= pwdata[FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_KTOP:    prdata = CFG_DW'(cfg.k_top);
			REG_KMID:    prdata = CFG_DW'(cfg.k_mid);
			REG_KBOT:    prdata = CFG_DW'(cfg.k_bot);
			REG_FWIDTH:  prdata = CFG_DW'(cfg.fwidth);
			REG_FHEIGHT: prdata = CFG_DW'(cfg.fheight);
			default:     prdata = '0;
		endcase
	end

endmodule

// ----- src/c3f_front.sv -----
// ----------------------------------------------------------------------------
// c3f_front: pixel intake, line stores and window
// Tracks the raster position, keeps the two previous rows in one line
// memory, shifts the 3x3 window and hands interior windows to the queue.
// ----------------------------------------------------------------------------
module c3f_front import c3f_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [PIX_W-1:0]  s_tdata,
	input  logic [QCNT_W-1:0] q_count,
	output logic              push,
	output win_item_t         push_item
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int WCMP = ((CW > FW_W) ? CW : FW_W) + 1;
	localparam int HCMP = ((RW > FH_W) ? RW : FH_W) + 1;

	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [WCMP-1:0] w_in;
	logic [WCMP-1:0] w_last;
	logic [HCMP-1:0] h_in;
	logic [HCMP-1:0] h_last;
	logic            end_col;
	logic            end_row;
	logic            accept;
	logic            interior;

	logic            valid_s1;
	pix_t            px_s1;
	logic [CW-1:0]   idx_s1;
	logic            prod_s1;
	logic            last_s1;
	logic [2*PIX_W-1:0] line_s1;

	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

	logic [8:0][PIX_W-1:0] win_q;
	logic [8:0][PIX_W-1:0] win_next;

	always_comb begin
		w_in = WCMP'(cfg.fwidth);
		if (w_in < WCMP'(3)) begin
			w_last = WCMP'(2);
		end else if (w_in > WCMP'(MAX_WIDTH)) begin
			w_last = WCMP'(MAX_WIDTH - 1);
		end else begin
			w_last = w_in - WCMP'(1);
		end
		h_in = HCMP'(cfg.fheight);
		if (h_in < HCMP'(3)) begin
			h_last = HCMP'(2);
		end else if (h_in > HCMP'(MAX_HEIGHT)) begin
			h_last = HCMP'(MAX_HEIGHT - 1);
		end else begin
			h_last = h_in - HCMP'(1);
		end
	end

	assign end_col  = WCMP'(col_q) >= w_last;
	assign end_row  = HCMP'(row_q) >= h_last;
	assign interior = (col_q >= CW'(2)) && (row_q >= RW'(2));
	assign accept   = s_tvalid & s_tready;
	assign s_tready = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(valid_s1 & prod_s1))
		< (QCNT_W + 1)'(QUEUE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (end_col) begin
					col_q <= '0;
					row_q <= end_row ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= s_tdata;
			idx_s1  <= col_q;
			prod_s1 <= interior;
			last_s1 <= end_col & end_row;
		end
	end

	// Each entry holds the older row's pixel above the newer row's pixel.
	always_ff @(posedge clk) begin
		if (accept) begin
			line_s1 <= line_mem[col_q];
		end
		if (valid_s1) begin
			line_mem[idx_s1] <= {line_s1[PIX_W-1:0], px_s1};
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_next[3*r]     = win_q[3*r + 1];
			win_next[3*r + 1] = win_q[3*r + 2];
		end
		win_next[2] = line_s1[2*PIX_W-1:PIX_W];
		win_next[5] = line_s1[PIX_W-1:0];
		win_next[8] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (valid_s1) begin
			win_q <= win_next;
		end
	end

	assign push           = valid_s1 & prod_s1;
	assign push_item.last = last_s1;
	assign push_item.pix  = win_next;

endmodule

// ----- src/c3f_queue.sv -----
// ----------------------------------------------------------------------------
// c3f_queue: window queue
// Small first-in first-out store that decouples window capture from the
// multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module c3f_queue import c3f_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  win_item_t                    push_item,
	input  logic                         pop,
	output logic                         q_valid,
	output win_item_t                    q_item,
	output logic [$clog2(DEPTH + 1)-1:0] q_count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	win_item_t   slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] cnt_q;

	assign q_valid = cnt_q != '0;
	assign q_item  = slot_q[rd_q];
	assign q_count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + NW'(push) - NW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

endmodule

// ----- src/c3f_back.sv -----
// ----------------------------------------------------------------------------
// c3f_back: weighted window sum
// Three-stage pipeline: nine products, three row sums, then the total in
// the output register that drives the master side.
// ----------------------------------------------------------------------------
module c3f_back import c3f_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  q_valid,
	input  win_item_t             q_item,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	logic [2:0][KROW_W-1:0] krow;

	logic                     valid_s1;
	logic                     last_s1;
	logic signed [PROD_W-1:0] prod_s1 [9];
	logic signed [PROD_W-1:0] prod_c  [9];

	logic                     valid_s2;
	logic                     last_s2;
	logic signed [FILT_W-1:0] rsum_s2 [3];

	logic                     out_valid_q;
	logic                     out_last_q;
	logic signed [FILT_W-1:0] filt_q;

	logic out_ready;
	logic s2_ready;
	logic s1_ready;

	assign krow[0] = cfg.k_top;
	assign krow[1] = cfg.k_mid;
	assign krow[2] = cfg.k_bot;

	assign out_ready = !out_valid_q || m_tready;
	assign s2_ready  = !valid_s2 || out_ready;
	assign s1_ready  = !valid_s1 || s2_ready;
	assign pop       = q_valid & s1_ready;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_c[3*r + c] = $signed({1'b0, q_item.pix[3*r + c]})
					* kcoef(krow[r], 2'(c));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= q_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			if (out_ready) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1 <= prod_c;
			last_s1 <= q_item.last;
		end
		if (s2_ready && valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				rsum_s2[r] <= FILT_W'(prod_s1[3*r]) + FILT_W'(prod_s1[3*r + 1])
					+ FILT_W'(prod_s1[3*r + 2]);
			end
			last_s2 <= last_s1;
		end
		if (out_ready && valid_s2) begin
			filt_q     <= rsum_s2[0] + rsum_s2[1] + rsum_s2[2];
			out_last_q <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_DATA_W - FILT_W){1'b0}}, filt_q};

endmodule

// ----- src/conv3x3_image_filter_unit.sv -----
// ----------------------------------------------------------------------------
// conv3x3_image_filter_unit: 3x3 convolution filter over a pixel stream
// Applies a configurable signed 3x3 kernel to a raster stream of 8-bit
// pixels and emits one 20-bit weighted sum per interior pixel.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock when the output side keeps up.
// The front reads and rewrites one line memory entry per pixel (one read and
// one write port), so it takes a pixel while writing back the last. Each
// interior window is queued and then passes a multiply stage, a row-sum
// stage and the output register. Border pixels give no output word; the
// last interior word of a frame carries tlast. Width and height are clamped
// to 3..MAX_WIDTH and 3..MAX_HEIGHT. The user is to write configuration only
// while the stream is idle; the block itself does not enforce it.
module conv3x3_image_filter_unit import c3f_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [19:0] filtered, [23:20] zero
	output logic                  m_tlast,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_AW-1:0]     paddr,
	input  logic [CFG_DW-1:0]     pwdata,
	output logic [CFG_DW-1:0]     prdata,
	output logic                  pready
);

	cfg_t              cfg;
	logic              q_push;
	win_item_t         q_push_item;
	logic              q_pop;
	logic              q_valid;
	win_item_t         q_item;
	logic [QCNT_W-1:0] q_count;

	c3f_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	c3f_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_count   (q_count),
		.push      (q_push),
		.push_item (q_push_item)
	);

	c3f_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.pop       (q_pop),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_count   (q_count)
	);

	c3f_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTH
	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
		else $error("window queue written while full");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_count != '0))
		else $error("window queue read while empty");

	a_push_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> $past(s_tvalid && s_tready))
		else $error("window pushed without a pixel taken in the cycle before");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the 3x3 image filter
// Streams pixel frames into the filter under random sender gaps and receiver
// stalls, predicts every weighted window sum and frame end in a model of its
// own, and compares each output word with the oldest prediction. The kernel
// and the frame size are rewritten between phases, including the clamped
// extremes, unused register addresses and size changes in mid-frame.
// ----------------------------------------------------------------------------
module tb;
	import c3f_pkg::*;

	localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REG_SPARE_LAST  = 3'd7;
	localparam int DRAIN_CYCLES  = 16;
	localparam int LONG_HOLD     = 400;
	localparam int RANDOM_ITEMS  = 620;
	localparam int PHASE_ITEMS   = 160;

	typedef struct packed {
		logic [FILT_W-1:0] filtered;
		logic              last;
	} filter_result_t;

	typedef enum {RX_STEADY, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata  = '0;      // [7:0] pixel
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;            // [19:0] filtered, [23:20] zero
	logic                  m_tlast;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [CFG_AW-1:0]     paddr    = '0;
	logic [CFG_DW-1:0]     pwdata   = '0;
	logic [CFG_DW-1:0]     prdata;
	logic                  pready;

	conv3x3_image_filter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Filter model state and configuration.
	bit [KROW_W-1:0] k_rows [3] = '{KTOP_RST, KMID_RST, KBOT_RST};
	bit [FW_W-1:0]   fw_reg = FWIDTH_RST;
	bit [FH_W-1:0]   fh_reg = FHEIGHT_RST;
	bit [PIX_W-1:0]  line_old [MAX_WIDTH_DEF];
	bit [PIX_W-1:0]  line_new [MAX_WIDTH_DEF];
	bit [PIX_W-1:0]  win [3][3];
	int unsigned     col_cnt = 0;
	int unsigned     row_cnt = 0;

	filter_result_t pending_sums [$];
	int mismatches = 0;

	int burst_left = 0;
	bit sender_steady = 1'b0;
	int hold_req = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void predict_window_sum(pix_t px);
		int unsigned w, h, idx;
		bit end_col, end_row;
		int sum;
		bit signed [PIX_W-1:0] coef;
		filter_result_t res;
		w = clamp_dim(fw_reg, MAX_WIDTH_DEF);
		h = clamp_dim(fh_reg, MAX_HEIGHT_DEF);
		idx = col_cnt % MAX_WIDTH_DEF;
		end_col = col_cnt >= w - 1;
		end_row = row_cnt >= h - 1;
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = line_old[idx];
		win[1][2] = line_new[idx];
		win[2][2] = px;
		line_old[idx] = line_new[idx];
		line_new[idx] = px;
		if (row_cnt >= 2 && col_cnt >= 2) begin
			sum = 0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					coef = k_rows[r][8*c +: 8];
					sum += int'(win[r][c]) * int'(coef);
				end
			end
			res.filtered = sum[FILT_W-1:0];
			res.last = end_row && end_col;
			pending_sums.push_back(res);
		end
		if (end_col) begin
			col_cnt = 0;
			row_cnt = end_row ? 0 : row_cnt + 1;
		end else begin
			col_cnt = col_cnt + 1;
		end
	endfunction

	task automatic send_pixel(pix_t px);
		int gap;
		if (burst_left == 0) begin
			gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		predict_window_sum(px);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [CFG_DW-1:0] value);
		paddr <= {idx, 2'b00};
		pwdata <= value;
		pwrite <= 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_KTOP:    k_rows[0] = value[KROW_W-1:0];
			REG_KMID:    k_rows[1] = value[KROW_W-1:0];
			REG_KBOT:    k_rows[2] = value[KROW_W-1:0];
			REG_FWIDTH:  fw_reg = value[FW_W-1:0];
			REG_FHEIGHT: fh_reg = value[FH_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [CFG_DW-1:0] with_noise(int unsigned v, int unsigned w);
		logic [CFG_DW-1:0] mask;
		mask = (32'h1 << w) - 1;
		return ($urandom & ~mask) | (v & mask);
	endfunction

	function automatic logic [CFG_DW-1:0] random_kernel_row();
		logic [CFG_DW-1:0] v;
		v = $urandom;
		for (int b = 0; b < 3; b++) begin
			case ($urandom_range(0, 4))
				0: v[8*b +: 8] = 8'h80;
				1: v[8*b +: 8] = 8'h7F;
				2: v[8*b +: 8] = 8'h00;
				3: v[8*b +: 8] = 8'hFF;
				default: ;
			endcase
		end
		return v;
	endfunction

	function automatic pix_t random_pixel();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return pix_t'($urandom);
		endcase
	endfunction

	// Receiver stall pattern, with a long hold-off on request.
	always @(posedge clk) begin : rx_pattern
		int hold_cnt;
		int phase_left;
		int tick;
		rx_mode_t mode;
		if (hold_req != 0) begin
			hold_cnt = hold_req;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else begin
			if (phase_left <= 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				phase_left = $urandom_range(20, 200);
			end
			phase_left--;
			tick++;
			case (mode)
				RX_STEADY:   m_tready <= 1'b1;
				RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
				RX_PERIODIC: m_tready <= (tick % 5) != 0;
				default:     m_tready <= $urandom_range(0, 3) == 0;
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		filter_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_sums.size() == 0) begin
				$error("unexpected word: filtered %0d, last %0b",
					$signed(m_tdata[FILT_W-1:0]), m_tlast);
				mismatches++;
			end else begin
				want = pending_sums.pop_front();
				if (m_tdata[FILT_W-1:0] !== want.filtered) begin
					$error("filtered: expected %0d, got %0d",
						$signed(want.filtered), $signed(m_tdata[FILT_W-1:0]));
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("last_of_frame: expected %0b, got %0b", want.last, m_tlast);
					mismatches++;
				end
				if (m_tdata[OUT_DATA_W-1:FILT_W] !== '0) begin
					$error("tdata pad: expected 0, got %0h", m_tdata[OUT_DATA_W-1:FILT_W]);
					mismatches++;
				end
			end
		end
	end

	task automatic test_defaults();
		for (int i = 0; i < 13; i++) send_pixel((i % 2) ? 8'hFF : 8'h00);
		wait_drain();
		// Shrinking both sizes here makes the counters wrap at the next pixel.
		write_reg(REG_FWIDTH, with_noise(3, FW_W));
		write_reg(REG_FHEIGHT, with_noise(3, FH_W));
		send_pixel(8'hFF);
	endtask

	task automatic test_kernel_extremes();
		wait_drain();
		write_reg(REG_KTOP, 32'h00808080);
		write_reg(REG_KMID, 32'h00808080);
		write_reg(REG_KBOT, 32'h00808080);
		for (int i = 0; i < 9; i++) send_pixel(8'hFF);
	endtask

	task automatic test_orientation();
		wait_drain();
		write_reg(REG_KTOP, 32'h00030201);
		write_reg(REG_KMID, 32'h00060504);
		write_reg(REG_KBOT, 32'h00090807);
		for (int i = int'(REG_SPARE_FIRST); i <= int'(REG_SPARE_LAST); i++)
			write_reg(i[2:0], $urandom);
		for (int i = 1; i <= 9; i++) send_pixel(pix_t'(i));
	endtask

	task automatic test_height_shrink();
		wait_drain();
		write_reg(REG_KTOP, random_kernel_row());
		write_reg(REG_FHEIGHT, with_noise(8191, FH_W));
		for (int i = 0; i < 15; i++) send_pixel(random_pixel());
		wait_drain();
		write_reg(REG_FHEIGHT, with_noise(4, FH_W));
		for (int i = 0; i < 3; i++) send_pixel(random_pixel());
	endtask

	task automatic test_max_width();
		wait_drain();
		write_reg(REG_KMID, random_kernel_row());
		write_reg(REG_FWIDTH, with_noise(2047, FW_W));
		write_reg(REG_FHEIGHT, with_noise(3, FH_W));
		for (int i = 0; i < MAX_WIDTH_DEF; i++) send_pixel(random_pixel());
		wait_drain();
		// One full row at the clamped width, then the frame ends at width three.
		write_reg(REG_FWIDTH, with_noise(3, FW_W));
		for (int i = 0; i < 6; i++) send_pixel(random_pixel());
	endtask

	task automatic test_backpressure();
		wait_drain();
		write_reg(REG_FWIDTH, with_noise(4, FW_W));
		write_reg(REG_FHEIGHT, with_noise(4, FH_W));
		sender_steady = 1'b1;
		hold_req = LONG_HOLD;
		for (int i = 0; i < 64; i++) send_pixel(random_pixel());
		sender_steady = 1'b0;
	endtask

	task automatic test_random_frames();
		int sent, count, to_end;
		int unsigned w, h, cur_w, wv, hv;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_drain();
			if ($urandom_range(0, 1)) write_reg(REG_KTOP, random_kernel_row());
			if ($urandom_range(0, 1)) write_reg(REG_KMID, random_kernel_row());
			if ($urandom_range(0, 1)) write_reg(REG_KBOT, random_kernel_row());
			if ($urandom_range(0, 1)) begin
				cur_w = clamp_dim(fw_reg, MAX_WIDTH_DEF);
				if (col_cnt != 0 || row_cnt != 0) begin
					// Within a frame the width may only shrink.
					wv = $urandom_range(0, cur_w);
				end else begin
					case ($urandom_range(0, 15))
						10, 11, 12, 13: wv = $urandom_range(13, 40);
						14:             wv = $urandom_range(MAX_WIDTH_DEF, 2047);
						15:             wv = $urandom_range(41, 300);
						default:        wv = $urandom_range(0, 12);
					endcase
				end
				write_reg(REG_FWIDTH, with_noise(wv, FW_W));
			end
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 15))
					10, 11, 12, 13: hv = $urandom_range(11, 40);
					14:             hv = $urandom_range(MAX_HEIGHT_DEF, 8191);
					15:             hv = $urandom_range(41, 300);
					default:        hv = $urandom_range(0, 10);
				endcase
				write_reg(REG_FHEIGHT, with_noise(hv, FH_W));
			end
			w = clamp_dim(fw_reg, MAX_WIDTH_DEF);
			h = clamp_dim(fh_reg, MAX_HEIGHT_DEF);
			to_end = (row_cnt < h && col_cnt < w) ? int'(w * h - row_cnt * w - col_cnt) : 0;
			if (to_end > 0 && to_end <= PHASE_ITEMS && $urandom_range(0, 3) != 0) begin
				count = to_end;
				while (count + w * h <= PHASE_ITEMS && $urandom_range(0, 2) != 0)
					count += w * h;
			end else begin
				count = $urandom_range(1, PHASE_ITEMS);
			end
			for (int i = 0; i < count; i++) send_pixel(random_pixel());
			sent += count;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_kernel_extremes();
		test_orientation();
		test_height_shrink();
		test_max_width();
		test_backpressure();
		test_random_frames();
		wait_drain();
		if (mismatches == 0 && pending_sums.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
